@@ sv/sutf_pkg.sv @@
`timescale 1ns / 1ps

package sutf_pkg;

  // Identifier and data length of the text-formatting element.
  localparam logic [7:0] FmtIei  = 8'h0a;
  localparam logic [7:0] FmtIedl = 8'd3;

  // A message shorter than this never reports a hit.
  localparam logic [8:0] MinOctets = 9'd6;

  // The octet count saturates here; the header end never exceeds it.
  localparam logic [8:0] CountMax = 9'd256;

  // Phases of the element walk.
  typedef enum logic [2:0] {
    PhLenHdr = 3'd0,
    PhId     = 3'd1,
    PhLen    = 3'd2,
    PhValue  = 3'd3,
    PhDone   = 3'd4
  } phase_e;

  // One input item: a message octet and its last-octet flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       found;
    logic [7:0] start_position;
    logic [7:0] formatted_length;
    logic [7:0] format_mode;
  } res_item_t;

endpackage

@@ sv/sutf_ie_walker.sv @@
`timescale 1ns / 1ps

module sutf_ie_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sutf_pkg::in_item_t  item_i,
  output sutf_pkg::res_item_t res_o
);

  sutf_pkg::phase_e phase_q, phase_d;
  logic [8:0] count_q, count_d;
  logic [8:0] hdr_end_q, hdr_end_d;
  logic [7:0] remain_q, remain_d;
  logic       matches_q, matches_d;
  logic       walk_done_q, walk_done_d;
  logic       match_q, match_d;
  logic [7:0] cap_q [3];
  logic [7:0] cap_d [3];

  logic [7:0] din;
  logic [9:0] pos_p1;
  logic [7:0] remain_dec;
  logic [1:0] cap_idx;
  logic       ok;

  assign din    = item_i.data_byte;
  assign pos_p1 = {1'b0, count_q} + 10'd1;

  // Next state of the element walk for the octet in hand.
  always_comb begin
    phase_d     = phase_q;
    hdr_end_d   = hdr_end_q;
    remain_d    = remain_q;
    matches_d   = matches_q;
    walk_done_d = walk_done_q;
    match_d     = match_q;
    cap_d       = cap_q;
    remain_dec  = (remain_q != 8'd0) ? remain_q - 8'd1 : 8'd0;
    cap_idx     = 2'd3 - remain_q[1:0];

    case (phase_q)
      sutf_pkg::PhLenHdr: begin
        hdr_end_d = {1'b0, din} + 9'd1;
        matches_d = 1'b0;
        // The first element needs room for its identifier and length.
        if (hdr_end_d >= 9'd3) begin
          phase_d = sutf_pkg::PhId;
        end else begin
          walk_done_d = 1'b1;
          match_d     = 1'b0;
          phase_d     = sutf_pkg::PhDone;
        end
      end
      sutf_pkg::PhId: begin
        matches_d = (din == sutf_pkg::FmtIei);
        phase_d   = sutf_pkg::PhLen;
      end
      sutf_pkg::PhLen: begin
        if (pos_p1 + {2'b00, din} > {1'b0, hdr_end_q}) begin
          // The element runs past the header.
          walk_done_d = 1'b1;
          match_d     = 1'b0;
          phase_d     = sutf_pkg::PhDone;
        end else if (matches_q && din == sutf_pkg::FmtIedl) begin
          remain_d = sutf_pkg::FmtIedl;
          phase_d  = sutf_pkg::PhValue;
        end else begin
          matches_d = 1'b0;
          if (din == 8'd0) begin
            if (pos_p1 + 10'd2 <= {1'b0, hdr_end_q}) begin
              phase_d = sutf_pkg::PhId;
            end else begin
              walk_done_d = 1'b1;
              match_d     = 1'b0;
              phase_d     = sutf_pkg::PhDone;
            end
          end else begin
            remain_d = din;
            phase_d  = sutf_pkg::PhValue;
          end
        end
      end
      sutf_pkg::PhValue: begin
        if (matches_q && remain_q >= 8'd1 && remain_q <= 8'd3) begin
          cap_d[cap_idx] = din;
        end
        remain_d = remain_dec;
        if (remain_dec == 8'd0) begin
          if (matches_q) begin
            walk_done_d = 1'b1;
            match_d     = 1'b1;
            phase_d     = sutf_pkg::PhDone;
          end else begin
            matches_d = 1'b0;
            if (pos_p1 + 10'd2 <= {1'b0, hdr_end_q}) begin
              phase_d = sutf_pkg::PhId;
            end else begin
              walk_done_d = 1'b1;
              match_d     = 1'b0;
              phase_d     = sutf_pkg::PhDone;
            end
          end
        end
      end
      default: begin
        // Walk over: octets are ignored until the last one.
      end
    endcase

    count_d = (count_q == sutf_pkg::CountMax) ? count_q : count_q + 9'd1;
  end

  // The result looks at the state as it stands after this octet.
  always_comb begin
    ok = match_d && walk_done_d && (count_d >= sutf_pkg::MinOctets) &&
         (hdr_end_d <= count_d);
    res_o.found            = ok;
    res_o.start_position   = ok ? cap_d[0] : 8'd0;
    res_o.formatted_length = ok ? cap_d[1] : 8'd0;
    res_o.format_mode      = ok ? cap_d[2] : 8'd0;
  end

  // Walk state; the last octet of a message returns it to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sutf_pkg::PhLenHdr;
      count_q     <= 9'd0;
      hdr_end_q   <= 9'd0;
      remain_q    <= 8'd0;
      matches_q   <= 1'b0;
      walk_done_q <= 1'b0;
      match_q     <= 1'b0;
      cap_q[0]    <= 8'd0;
      cap_q[1]    <= 8'd0;
      cap_q[2]    <= 8'd0;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        phase_q     <= sutf_pkg::PhLenHdr;
        count_q     <= 9'd0;
        hdr_end_q   <= 9'd0;
        remain_q    <= 8'd0;
        matches_q   <= 1'b0;
        walk_done_q <= 1'b0;
        match_q     <= 1'b0;
        cap_q[0]    <= 8'd0;
        cap_q[1]    <= 8'd0;
        cap_q[2]    <= 8'd0;
      end else begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        hdr_end_q   <= hdr_end_d;
        remain_q    <= remain_d;
        matches_q   <= matches_d;
        walk_done_q <= walk_done_d;
        match_q     <= match_d;
        cap_q       <= cap_d;
      end
    end
  end

endmodule

@@ sv/sms_udh_text_format_parser.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (data_byte, last_byte)
// out     | output    | out_valid_o / out_stall_i | out_data_o (found, start_position,
//         |           |                           |  formatted_length, format_mode)
//
// One octet is taken every cycle unless the input stalls. An accepted octet is held
// in the input register while the element walker works on it; a last octet's result
// is then registered in the output register.
// Reset clears the walk and the valid flags of the input and output registers.
// The input stalls only when a last octet waits and the output register still
// holds a result that is stalled; ordinary octets keep flowing meanwhile.

module sms_udh_text_format_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sutf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sutf_pkg::res_item_t out_data_o
);

  logic                s1_valid_q, s1_valid_d;
  sutf_pkg::in_item_t  s1_item_q;
  logic                s1_adv, s1_fire, in_accept;
  sutf_pkg::res_item_t res;
  logic                out_valid_q, out_valid_d;
  sutf_pkg::res_item_t out_data_q;

  // A held octet may move on unless it makes a result with nowhere to go.
  assign s1_adv     = !s1_item_q.last_byte || !(out_valid_q && out_stall_i);
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register control.
  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
  end

  sutf_ie_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_item_q),
    .res_o  (res)
  );

  // Output register control.
  always_comb begin
    if (s1_fire && s1_item_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last_byte) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ sv/sutf_checker.sv @@
`timescale 1ns / 1ps

module sutf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sutf_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sutf_pkg::res_item_t out_data_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A miss carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.start_position == 8'd0 && out_data_o.formatted_length == 8'd0 &&
      out_data_o.format_mode == 8'd0)
    else $error("fields not zero on a miss");

  // The input only stalls behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A fresh result follows an accepted last octet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && in_data_i.last_byte, 2))
    else $error("result item without a last octet");

endmodule

bind sms_udh_text_format_parser sutf_checker u_sutf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ bench/udh_format_checker.sv @@
`timescale 1ns / 1ps

module udh_format_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  sutf_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  sutf_pkg::res_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Shadow copy of the element walk.
  sutf_pkg::phase_e phase;
  logic [8:0] octet_count;
  logic [8:0] header_end;
  logic [7:0] value_left;
  logic       elem_is_fmt;
  logic       fmt_captured;
  logic [7:0] fmt_octets [3];

  sutf_pkg::res_item_t expected_fmt_q [$];
  int         mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_fmt_q.size();

  task automatic clear_walk();
    phase        = sutf_pkg::PhLenHdr;
    octet_count  = '0;
    header_end   = '0;
    value_left   = '0;
    elem_is_fmt  = 1'b0;
    fmt_captured = 1'b0;
    for (int i = 0; i < 3; i++) fmt_octets[i] = '0;
  endtask

  task automatic close_walk(input logic hit);
    fmt_captured = hit;
    phase        = sutf_pkg::PhDone;
  endtask

  // An element may start only if its identifier and length octets fit.
  task automatic next_element(input logic [9:0] offset);
    elem_is_fmt = 1'b0;
    if (offset + 10'd2 <= {1'b0, header_end}) begin
      phase = sutf_pkg::PhId;
    end else begin
      close_walk(1'b0);
    end
  endtask

  // Advance the walk by one octet and, on the last one, predict the result.
  task automatic walk_octet(input sutf_pkg::in_item_t item);
    logic [9:0] pos;
    logic [7:0] d;
    logic       ok;
    sutf_pkg::res_item_t res;
    pos = {1'b0, octet_count};
    d   = item.data_byte;
    case (phase)
      sutf_pkg::PhLenHdr: begin
        header_end = {1'b0, d} + 9'd1;
        next_element(10'd1);
      end
      sutf_pkg::PhId: begin
        elem_is_fmt = (d == sutf_pkg::FmtIei);
        phase       = sutf_pkg::PhLen;
      end
      sutf_pkg::PhLen: begin
        if (pos + 10'd1 + {2'b00, d} > {1'b0, header_end}) begin
          close_walk(1'b0);
        end else if (elem_is_fmt && d == sutf_pkg::FmtIedl) begin
          value_left = sutf_pkg::FmtIedl;
          phase      = sutf_pkg::PhValue;
        end else begin
          elem_is_fmt = 1'b0;
          if (d == 8'd0) begin
            next_element(pos + 10'd1);
          end else begin
            value_left = d;
            phase      = sutf_pkg::PhValue;
          end
        end
      end
      sutf_pkg::PhValue: begin
        if (elem_is_fmt && value_left >= 8'd1 && value_left <= 8'd3) begin
          fmt_octets[2'd3 - value_left[1:0]] = d;
        end
        if (value_left > 8'd0) value_left = value_left - 8'd1;
        if (value_left == 8'd0) begin
          if (elem_is_fmt) begin
            close_walk(1'b1);
          end else begin
            next_element(pos + 10'd1);
          end
        end
      end
      default: ;
    endcase

    // The octet count saturates.
    octet_count = (pos + 10'd1 > {1'b0, sutf_pkg::CountMax}) ? sutf_pkg::CountMax :
                  octet_count + 9'd1;

    if (item.last_byte) begin
      ok = fmt_captured && octet_count >= sutf_pkg::MinOctets &&
           header_end <= octet_count;
      res.found            = ok;
      res.start_position   = ok ? fmt_octets[0] : 8'd0;
      res.formatted_length = ok ? fmt_octets[1] : 8'd0;
      res.format_mode      = ok ? fmt_octets[2] : 8'd0;
      expected_fmt_q.push_back(res);
      clear_walk();
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input sutf_pkg::res_item_t got);
    sutf_pkg::res_item_t want;
    if (expected_fmt_q.size() == 0) begin
      $error("result item with none expected: found %0h start %0h length %0h mode %0h",
             got.found, got.start_position, got.formatted_length, got.format_mode);
      mismatches++;
    end else begin
      want = expected_fmt_q.pop_front();
      compare_field("found", {7'd0, want.found}, {7'd0, got.found});
      compare_field("start_position", want.start_position, got.start_position);
      compare_field("formatted_length", want.formatted_length, got.formatted_length);
      compare_field("format_mode", want.format_mode, got.format_mode);
    end
  endtask

  initial mismatches = 0;

  // Both channels are sampled at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      expected_fmt_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) walk_octet(in_data_i);
    end
  end

endmodule

@@ bench/tb_sms_udh_text_format_parser.sv @@
`timescale 1ns / 1ps

module tb_sms_udh_text_format_parser;

  localparam int CycleLimit  = 300000;
  localparam int RandomItems = 700;
  localparam int QuietFrom   = 560;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  sutf_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  sutf_pkg::res_item_t out_data;

  int        fail_count;
  int        pending;
  int        item_count;
  int        cycle_count;
  bit        quiet;
  logic [7:0] octets [$];

  sms_udh_text_format_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  udh_format_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_sms_udh_text_format_parser: FAIL");
      $finish;
    end
  end

  // The result side stalls in random bursts until the quiet stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait for acceptance.
  task automatic send_octet(input logic [7:0] d, input logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, last_byte: last};
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    item_count++;
  endtask

  task automatic send_message();
    for (int i = 0; i < octets.size(); i++) begin
      send_octet(octets[i], i == octets.size() - 1);
    end
    octets.delete();
  endtask

  // Build a header of the given length from elements, optionally placing the
  // text-formatting element and optionally ending on an overrunning element.
  task automatic build_header(input int udhl, input bit want_fmt, input bit broken);
    int left;
    int len;
    bit placed;
    logic [7:0] id;
    left   = udhl;
    placed = 1'b0;
    octets.push_back(udhl[7:0]);
    while (left > 0) begin
      if (left == 1) begin
        octets.push_back(8'($urandom_range(0, 255)));
        left = 0;
      end else if (want_fmt && !placed && left >= 5 && $urandom_range(0, 2) == 0) begin
        octets.push_back(sutf_pkg::FmtIei);
        octets.push_back(sutf_pkg::FmtIedl);
        repeat (3) octets.push_back(8'($urandom_range(0, 255)));
        placed = 1'b1;
        left   = left - 5;
      end else begin
        id = ($urandom_range(0, 3) == 0) ? sutf_pkg::FmtIei : 8'($urandom_range(0, 255));
        if (broken && $urandom_range(0, 3) == 0) begin
          len = left - 1 + $urandom_range(0, 3);
          if (len > 255) len = 255;
          octets.push_back(id);
          octets.push_back(len[7:0]);
          left = 0;
        end else begin
          len = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(0, 6);
          if (len > left - 2) len = left - 2;
          octets.push_back(id);
          octets.push_back(len[7:0]);
          repeat (len) octets.push_back(8'($urandom_range(0, 255)));
          left = left - 2 - len;
        end
      end
    end
  endtask

  task automatic add_text(input int n);
    repeat (n) octets.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic directed_messages();
    // A single-octet message.
    octets = '{8'h00};
    send_message();
    // Smallest message with a hit, value octets at their extremes.
    octets = '{8'h05, sutf_pkg::FmtIei, sutf_pkg::FmtIedl, 8'hff, 8'h00, 8'hff};
    send_message();
    // Element captured but the message stops inside the header.
    octets = '{8'h07, sutf_pkg::FmtIei, sutf_pkg::FmtIedl, 8'h01, 8'h02, 8'h03};
    send_message();
    // Element length runs past the header end.
    octets = '{8'h05, sutf_pkg::FmtIei, 8'h04, 8'h00, 8'h00, 8'h00};
    send_message();
    // One octet left over in the header, too few to start an element.
    octets = '{8'h05, 8'h00, 8'h02, 8'haa, 8'hbb, 8'hcc};
    send_message();
  endtask

  task automatic random_message();
    int kind;
    int total;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // Long message to drive the octet count into saturation.
      build_header($urandom_range(200, 255), 1'b1, 1'b0);
      total = $urandom_range(256, 262);
      if (total > octets.size()) add_text(total - octets.size());
    end else if (kind < 74) begin
      build_header($urandom_range(0, 24), $urandom_range(0, 3) != 0, 1'b0);
      add_text($urandom_range(0, 8));
    end else if (kind < 88) begin
      // Broken messages: overrunning elements and truncated headers.
      build_header($urandom_range(0, 24), 1'b1, 1'b1);
      add_text($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) begin
        total = $urandom_range(1, octets.size());
        while (octets.size() > total) void'(octets.pop_back());
      end
    end else begin
      // Noise, biased towards the identifier and length of interest.
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0:       octets.push_back(sutf_pkg::FmtIei);
          1:       octets.push_back(sutf_pkg::FmtIedl);
          default: octets.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_message();
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    item_count = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_messages();
    while (item_count < RandomItems) begin
      if (item_count >= QuietFrom) quiet = 1'b1;
      random_message();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_sms_udh_text_format_parser: PASS");
    end else begin
      $display("tb_sms_udh_text_format_parser: FAIL");
    end
    $finish;
  end

endmodule
